// File: sv/mrg_pkg.sv
// Shared types, constants and helpers of the MRG32k3a generator.
// No dependencies; imported by mrg_ctrl, mrg_dp and the top level.
package mrg_pkg;

    localparam logic [31:0] ModOne      = 32'd4294967087;
    localparam logic [31:0] ModTwo      = 32'd4294944443;
    localparam logic [20:0] MulOneMid   = 21'd1403580;
    localparam logic [20:0] MulOneOld   = 21'd810728;
    localparam logic [20:0] MulTwoNew   = 21'd527612;
    localparam logic [20:0] MulTwoOld   = 21'd1370589;
    localparam logic [31:0] LcgMul      = 32'd69069;
    localparam logic [31:0] DefaultSeed = 32'd4357;
    localparam logic [31:0] HalfMask    = 32'hffff0000;

    // 2^32 mod m, used to fold the high part of a wide product back in
    localparam logic [15:0] FoldOne = 16'(64'h1_0000_0000 - 64'(ModOne));
    localparam logic [15:0] FoldTwo = 16'(64'h1_0000_0000 - 64'(ModTwo));

    localparam int NumWords  = 6;
    localparam int PerComp   = 3;
    localparam int ProdWidth = 53;
    localparam int AccWidth  = 54;

    typedef enum logic [1:0] {
        FUNC_GEN    = 2'd0,
        FUNC_RESEED = 2'd1,
        FUNC_LOAD   = 2'd2,
        FUNC_READ   = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_HI,
        ST_SEED_LO,
        ST_MUL_A,
        ST_MUL_B,
        ST_ADD,
        ST_FOLD,
        ST_SHIFT,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  word_index;
        logic [31:0] word_value;
    } t_in_item;

    typedef struct packed {
        logic [31:0] result_value;
        logic        error_flag;
    } t_out_item;

    typedef struct packed {
        logic item_load;
        logic q_init;
        logic q_step;
        logic seed_hi;
        logic seed_word;
        logic mul_a;
        logic mul_b;
        logic acc_add;
        logic fold;
        logic shift;
        logic respond;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       fold_done;
        logic       word_last;
        logic       out_free;
    } t_dp_sts;

    localparam logic [31:0] LcgResetQ = 32'(64'(LcgMul) * 64'(DefaultSeed) + 64'd1);

    function automatic logic [31:0] lcg_step(logic [31:0] x);
        return x * LcgMul + 32'd1;
    endfunction

endpackage

// File: sv/mrg32k3a_random_generator_unit.sv
// Top level of the MRG32k3a random generator: joins sequencer and datapath.
// Depends on mrg_pkg, mrg_ctrl and mrg_dp.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+--------------------
//  input    | in        | i_in_valid / o_in_stall      | i_in_item (t_in_item)
//  result   | out       | o_out_valid / i_out_stall    | o_out_item (t_out_item)
//  config   | in        | i_cfg_valid / o_cfg_ready    | i_cfg_seed_value
//
// Generate: from accept to result register the sequencer runs two multiply
// states, one add, a fold loop for the 54-bit reduction, shift and respond.
// Reseed: two LCG steps per state word. Load and read go straight to respond.
// After reset the block runs a reseed from seed 4357 with o_in_stall high.
// One item at a time; a waiting result does not block the next accept.
module mrg32k3a_random_generator_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mrg_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mrg_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [31:0]         i_cfg_seed_value
);
    import mrg_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    mrg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_func  (i_in_item.func),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mrg_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_in_item        (i_in_item),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_seed_value (i_cfg_seed_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_item       (o_out_item)
    );

endmodule

// File: sv/mrg_dp.sv
// Datapath of the MRG32k3a generator: state words, LCG, two modular lanes,
// output register and seed register. Depends on mrg_pkg.
module mrg_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mrg_pkg::t_dp_cmd     i_cmd,
    output mrg_pkg::t_dp_sts     o_sts,
    input  mrg_pkg::t_in_item    i_in_item,
    input  logic                 i_cfg_valid,
    input  logic [31:0]          i_cfg_seed_value,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mrg_pkg::t_out_item   o_out_item
);
    import mrg_pkg::*;

    logic [31:0]          r_word [NumWords];
    logic [31:0]          r_q;
    logic [15:0]          r_shi;
    logic [2:0]           r_k;
    logic [31:0]          r_seed;
    t_in_item             r_item;
    logic [ProdWidth-1:0] r_prod [2];
    logic [AccWidth-1:0]  r_acc  [2];
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [20:0]          mul_coef [2];
    logic [31:0]          mul_x    [2];
    logic [31:0]          lane_mod [2];
    logic [15:0]          lane_fold[2];
    logic [31:0]          lane_p   [2];
    logic [31:0]          seed_s;
    logic [31:0]          seed_red;
    logic [31:0]          seed_eff;
    logic [31:0]          gen_z;
    logic                 idx_one;
    logic                 idx_two;
    logic                 load_ok;
    t_out_item            n_out;
    logic [2:0]           n_k;

    assign lane_mod[0]  = ModOne;
    assign lane_mod[1]  = ModTwo;
    assign lane_fold[0] = FoldOne;
    assign lane_fold[1] = FoldTwo;

    // A*x - B*y is formed as A*x + B*(m - y), which keeps the sum non-negative
    always_comb begin
        if (i_cmd.mul_a) begin
            mul_coef[0] = MulOneMid;
            mul_x[0]    = r_word[1];
            mul_coef[1] = MulTwoNew;
            mul_x[1]    = r_word[5];
        end else begin
            mul_coef[0] = MulOneOld;
            mul_x[0]    = ModOne - r_word[0];
            mul_coef[1] = MulTwoOld;
            mul_x[1]    = ModTwo - r_word[3];
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            lane_p[l] = (r_acc[l][31:0] >= lane_mod[l]) ? r_acc[l][31:0] - lane_mod[l]
                                                         : r_acc[l][31:0];
        end
    end

    assign seed_s   = {r_shi, r_q[31:16]};
    assign seed_eff = (r_seed == 32'd0) ? DefaultSeed : r_seed;
    always_comb begin
        if (r_k < 3'(PerComp)) begin
            seed_red = (seed_s >= ModOne) ? seed_s - ModOne : seed_s;
        end else begin
            seed_red = (seed_s >= ModTwo) ? seed_s - ModTwo : seed_s;
        end
    end

    // p1 == p2 gives z = m1
    assign gen_z = (r_word[2] > r_word[5]) ? r_word[2] - r_word[5]
                 : 32'(33'(r_word[2]) + 33'(ModOne) - 33'(r_word[5]));

    assign idx_one = r_item.word_index < 3'(PerComp);
    assign idx_two = !idx_one && (r_item.word_index < 3'(NumWords));
    assign load_ok = (idx_one && r_item.word_value < ModOne)
                  || (idx_two && r_item.word_value < ModTwo);

    always_comb begin
        n_out = '0;
        unique case (t_func'(r_item.func))
            FUNC_GEN:    n_out.result_value = gen_z;
            FUNC_RESEED: n_out.result_value = 32'd0;
            FUNC_LOAD:   n_out.error_flag   = !load_ok;
            FUNC_READ: begin
                if (idx_one || idx_two) begin
                    n_out.result_value = r_word[r_item.word_index];
                end
            end
        endcase
    end

    assign n_k = r_k + 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= DefaultSeed;
            r_q         <= LcgResetQ;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_seed <= i_cfg_seed_value;
            end
            if (i_cmd.q_init) begin
                r_q <= lcg_step(seed_eff);
                r_k <= '0;
            end else if (i_cmd.q_step) begin
                r_q <= lcg_step(r_q);
            end
            if (i_cmd.seed_word) begin
                r_k <= n_k;
            end
            if (i_cmd.respond) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_item <= i_in_item;
        end
        if (i_cmd.seed_hi) begin
            r_shi <= r_q[31:16];
        end
        if (i_cmd.seed_word) begin
            r_word[r_k] <= seed_red;
        end
        for (int l = 0; l < 2; l++) begin
            if (i_cmd.mul_a) begin
                r_prod[l] <= ProdWidth'(mul_coef[l]) * ProdWidth'(mul_x[l]);
            end else if (i_cmd.mul_b) begin
                r_acc[l]  <= AccWidth'(r_prod[l]);
                r_prod[l] <= ProdWidth'(mul_coef[l]) * ProdWidth'(mul_x[l]);
            end else if (i_cmd.acc_add) begin
                r_acc[l] <= r_acc[l] + AccWidth'(r_prod[l]);
            end else if (i_cmd.fold) begin
                r_acc[l] <= AccWidth'(r_acc[l][AccWidth-1:32]) * AccWidth'(lane_fold[l])
                          + AccWidth'(r_acc[l][31:0]);
            end
        end
        if (i_cmd.shift) begin
            r_word[0] <= r_word[1];
            r_word[1] <= r_word[2];
            r_word[2] <= lane_p[0];
            r_word[3] <= r_word[4];
            r_word[4] <= r_word[5];
            r_word[5] <= lane_p[1];
        end
        if (i_cmd.respond) begin
            r_out <= n_out;
            if (t_func'(r_item.func) == FUNC_LOAD && load_ok) begin
                r_word[r_item.word_index] <= r_item.word_value;
            end
        end
    end

    assign o_sts.func      = r_item.func;
    assign o_sts.fold_done = (r_acc[0][AccWidth-1:32] == '0) && (r_acc[1][AccWidth-1:32] == '0);
    assign o_sts.word_last = (r_k == 3'(NumWords - 1));
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_word_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.seed_word |-> r_k < 3'(NumWords))
        else $error("reseed word slot out of range");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift |=> (r_word[2] < ModOne) && (r_word[5] < ModTwo))
        else $error("new state word not reduced");

    a_resp_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.respond |=> r_out_valid)
        else $error("response not presented");

endmodule

// File: sv/mrg_ctrl.sv
// Sequencer of the MRG32k3a generator: steps the datapath through reseed,
// generate and word access. Depends on mrg_pkg.
module mrg_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_in_func,
    output logic               o_in_stall,
    input  mrg_pkg::t_dp_sts   i_sts,
    output mrg_pkg::t_dp_cmd   o_cmd
);
    import mrg_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_boot;
    logic   n_boot;
    logic   in_acc;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SEED_HI;  // reset state comes from a reseed with the default seed
            r_boot  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_boot  <= n_boot;
        end
    end

    always_comb begin
        n_state = r_state;
        n_boot  = r_boot;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (t_func'(i_in_func))
                        FUNC_GEN:    n_state = ST_MUL_A;
                        FUNC_RESEED: n_state = ST_SEED_HI;
                        FUNC_LOAD:   n_state = ST_RESP;
                        FUNC_READ:   n_state = ST_RESP;
                    endcase
                end
            end
            ST_SEED_HI: n_state = ST_SEED_LO;
            ST_SEED_LO: begin
                if (i_sts.word_last) begin
                    n_state = r_boot ? ST_IDLE : ST_RESP;
                    n_boot  = 1'b0;
                end else begin
                    n_state = ST_SEED_HI;
                end
            end
            ST_MUL_A: n_state = ST_MUL_B;
            ST_MUL_B: n_state = ST_ADD;
            ST_ADD:   n_state = ST_FOLD;
            ST_FOLD: begin
                if (i_sts.fold_done) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: n_state = ST_RESP;
            ST_RESP: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.item_load = in_acc;
                o_cmd.q_init    = in_acc && (t_func'(i_in_func) == FUNC_RESEED);
            end
            ST_SEED_HI: begin
                o_cmd.seed_hi = 1'b1;
                o_cmd.q_step  = 1'b1;
            end
            ST_SEED_LO: begin
                o_cmd.seed_word = 1'b1;
                o_cmd.q_step    = 1'b1;
            end
            ST_MUL_A: o_cmd.mul_a   = 1'b1;
            ST_MUL_B: o_cmd.mul_b   = 1'b1;
            ST_ADD:   o_cmd.acc_add = 1'b1;
            ST_FOLD:  o_cmd.fold    = !i_sts.fold_done;
            ST_SHIFT: o_cmd.shift   = 1'b1;
            ST_RESP:  o_cmd.respond = i_sts.out_free;
            default:  o_cmd = '0;
        endcase
    end

    a_boot_seeding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_boot |-> (r_state == ST_SEED_HI || r_state == ST_SEED_LO))
        else $error("left boot reseed early");

    a_shift_to_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SHIFT |=> r_state == ST_RESP)
        else $error("generate result skipped");

    a_fold_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FOLD && i_sts.fold_done) |=> r_state == ST_SHIFT)
        else $error("fold loop did not exit");

endmodule
